[src/iss_pkg.sv]
`timescale 1ns / 1ps

package iss_pkg;

  localparam int unsigned POS_W  = 9;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ECNT_W = 9;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_WAIT,
    S_SHIFT,
    S_DRAIN,
    S_PLACE,
    S_RESP
  } state_t;

endpackage

[src/iss_if.sv]
`timescale 1ns / 1ps

interface iss_in_if import iss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] new_value;

  modport source (output valid, operation, position, new_value, input ready);
  modport sink   (input valid, operation, position, new_value, output ready);
endinterface

interface iss_out_if import iss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [ECNT_W-1:0]        element_count;
  logic [1:0]               status;

  modport source (output valid, read_value, element_count, status, input ready);
  modport sink   (input valid, read_value, element_count, status, output ready);
endinterface

[src/iss_mem.sv]
`timescale 1ns / 1ps

module iss_mem import iss_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/iss_ctrl.sv]
`timescale 1ns / 1ps

module iss_ctrl import iss_pkg::*; #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned AW       = 8,
  parameter int unsigned CNT_W    = 9
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_operation,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_new_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [ECNT_W-1:0]        out_element_count,
  output logic [1:0]               out_status,
  output logic                     mem_rd_en,
  output logic [AW-1:0]            mem_rd_addr,
  input  logic [DATA_W-1:0]        mem_rd_data,
  output logic                     mem_wr_en,
  output logic [AW-1:0]            mem_wr_addr,
  output logic [DATA_W-1:0]        mem_wr_data
);

  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned EXT_W = (CMP_W > ECNT_W) ? CMP_W : ECNT_W;
  localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);

  state_t            state_r, state_nxt;
  logic              ins_r, ins_nxt;
  logic [CMP_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  end_r, end_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]     waddr_r, waddr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] res_val_r, res_val_nxt;
  status_t           res_st_r, res_st_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic [ECNT_W-1:0] out_cnt_r, out_cnt_nxt;
  status_t           out_st_r, out_st_nxt;

  logic [CMP_W-1:0] posx;
  logic [CMP_W-1:0] cntx;
  logic [EXT_W-1:0] res_cnt_ext;

  assign posx        = CMP_W'(in_position);
  assign cntx        = CMP_W'(count_r);
  assign res_cnt_ext = EXT_W'(res_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r     <= ins_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    ptr_r     <= ptr_nxt;
    end_r     <= end_nxt;
    waddr_r   <= waddr_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    res_cnt_r <= res_cnt_nxt;
    out_val_r <= out_val_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ins_nxt       = ins_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    wr_pend_nxt   = wr_pend_r;
    waddr_nxt     = waddr_r;
    count_nxt     = count_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = ptr_r[AW-1:0];
    mem_wr_en     = 1'b0;
    mem_wr_addr   = waddr_r;
    mem_wr_data   = mem_rd_data;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_val_nxt = '0;
          res_st_nxt  = ST_OK;
          res_cnt_nxt = count_r;
          state_nxt   = S_RESP;
          unique case (op_t'(in_operation))
            OP_READ: begin
              if (posx < cntx) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = posx[AW-1:0];
                state_nxt   = S_READ_WAIT;
              end else begin
                res_st_nxt = ST_RANGE;
              end
            end
            OP_INSERT: begin
              if (posx > cntx) begin
                res_st_nxt = ST_RANGE;
              end else if (cntx >= CAP_X) begin
                res_st_nxt = ST_FULL;
              end else begin
                count_nxt   = count_r + 1'b1;
                res_cnt_nxt = count_r + 1'b1;
                ins_nxt     = 1'b1;
                pos_nxt     = posx;
                val_nxt     = in_new_value;
                wr_pend_nxt = 1'b0;
                if (posx == cntx) begin
                  state_nxt = S_PLACE;
                end else begin
                  // Move entries from the top down so nothing is overwritten.
                  ptr_nxt   = count_r - 1'b1;
                  end_nxt   = CNT_W'(posx);
                  state_nxt = S_SHIFT;
                end
              end
            end
            OP_REMOVE: begin
              if (posx >= cntx) begin
                res_st_nxt = ST_RANGE;
              end else begin
                count_nxt   = count_r - 1'b1;
                res_cnt_nxt = count_r - 1'b1;
                ins_nxt     = 1'b0;
                wr_pend_nxt = 1'b0;
                if (CMP_W'(posx + 1'b1) != cntx) begin
                  ptr_nxt   = CNT_W'(posx + 1'b1);
                  end_nxt   = count_r - 1'b1;
                  state_nxt = S_SHIFT;
                end
              end
            end
            OP_CLEAR: begin
              count_nxt   = '0;
              res_cnt_nxt = '0;
            end
          endcase
        end
      end
      S_READ_WAIT: begin
        res_val_nxt = mem_rd_data;
        state_nxt   = S_RESP;
      end
      S_SHIFT: begin
        // Read one entry per cycle; the entry read last cycle is written now.
        mem_rd_en   = 1'b1;
        mem_rd_addr = ptr_r[AW-1:0];
        mem_wr_en   = wr_pend_r;
        wr_pend_nxt = 1'b1;
        waddr_nxt   = ins_r ? AW'(ptr_r[AW-1:0] + 1'b1) : AW'(ptr_r[AW-1:0] - 1'b1);
        if (ptr_r == end_r) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ins_r ? ptr_r - 1'b1 : ptr_r + 1'b1;
        end
      end
      S_DRAIN: begin
        mem_wr_en   = 1'b1;
        wr_pend_nxt = 1'b0;
        state_nxt   = ins_r ? S_PLACE : S_RESP;
      end
      S_PLACE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_r[AW-1:0];
        mem_wr_data = val_r;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_cnt_nxt   = res_cnt_ext[ECNT_W-1:0];
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_read_value    = out_val_r;
  assign out_element_count = out_cnt_r;
  assign out_status        = out_st_r;

endmodule

[src/indexed_sequence_store.sv]
// A clear or a rejected request goes straight to the result stage; a read first fetches the entry.
// An insert shifts N entries up and then places the new value (only the placing when it appends);
// a remove shifts N entries down (none when it takes the last entry). The N entries move one per
// cycle through the single port pair of the entry memory. One request is in flight at a time; the
// next beat is accepted in the cycle after the result is loaded into the output register.
// Synchronous active-low reset clears the count and the control; memory is not cleared.
`timescale 1ns / 1ps

module indexed_sequence_store import iss_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  iss_in_if.sink    in_ch,
  iss_out_if.source out_ch
);

  // Address width for the entry memory and width of the count, which must
  // reach CAPACITY itself.
  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [DATA_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [DATA_W-1:0] mem_wr_data;

  // The sequencer accepts a beat only when idle. A read fetches the entry and
  // returns it; an insert or remove streams the tail of the sequence through
  // the memory, reading one entry per cycle and writing it one slot up or
  // down in the next cycle, so reads and writes never touch the same entry.
  // Results wait in an output register, so the sequencer is free as soon as
  // the register is loaded.
  iss_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_operation      (in_ch.operation),
    .in_position       (in_ch.position),
    .in_new_value      (in_ch.new_value),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_read_value    (out_ch.read_value),
    .out_element_count (out_ch.element_count),
    .out_status        (out_ch.status),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data)
  );

  // Entry storage: one write port, one registered read port.
  iss_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

[src/iss_checker.sv]
`timescale 1ns / 1ps

module iss_checker import iss_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_read_value,
  input logic [ECNT_W-1:0]        out_element_count,
  input logic [1:0]               out_status
);

  localparam logic [ECNT_W-1:0] CAP_CNT = ECNT_W'(CAPACITY);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_element_count) && $stable(out_status))
    else $error("result beat changed while stalled");

  // Only a successful read carries a value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_value == '0)
    else $error("failed request returned a nonzero value");

  // A full rejection reports a full store.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_element_count == CAP_CNT)
    else $error("full status with count below capacity");

  // One request at a time: no new beat right after an accepted one.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind indexed_sequence_store iss_checker #(
  .CAPACITY (CAPACITY)
) u_iss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_read_value    (out_ch.read_value),
  .out_element_count (out_ch.element_count),
  .out_status        (out_ch.status)
);
